>>> hw/rtl/tbaf_pkg.sv
// ============================================================================
// tbaf_pkg
// Shared widths, codes and item types of the Thumb branch address filter.
// ============================================================================
package tbaf_pkg;

  localparam int unsigned HalfW  = 16;
  localparam int unsigned IdxW   = 22;
  localparam int unsigned FieldW = 11;
  localparam int unsigned ModeW  = 2;

  // Filter mode codes; the unused code behaves like MODE_SUB
  localparam logic [ModeW-1:0] MODE_SUB      = 2'd0;
  localparam logic [ModeW-1:0] MODE_ADD      = 2'd1;
  localparam logic [ModeW-1:0] MODE_SUB_MOVT = 2'd2;
  localparam logic [ModeW-1:0] MODE_RESET    = MODE_SUB_MOVT;

  // Halfword pattern masks
  localparam logic [HalfW-1:0] TopMask    = 16'hF800;
  localparam logic [HalfW-1:0] BlFirst    = 16'hF000;
  localparam logic [HalfW-1:0] BlSecond   = 16'hF800;
  localparam logic [HalfW-1:0] MovtMask   = 16'hFBF0;
  localparam logic [HalfW-1:0] MovtMatch  = 16'hF2C0;

  // Distance from the first halfword's index to the branch base
  localparam logic [IdxW-1:0]  PcOffset   = 22'd2;

  // One result item
  typedef struct packed {
    logic [HalfW-1:0] half;
    logic             last;
  } res_t;

endpackage

>>> hw/rtl/tbaf_in_if.sv
// ============================================================================
// tbaf_in_if
// Input channel: one code halfword and its end-of-buffer mark per transfer.
// ============================================================================
interface tbaf_in_if
  import tbaf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] code_half;
  logic             is_last;

  modport source (output valid, output code_half, output is_last, input ready);
  modport sink   (input valid, input code_half, input is_last, output ready);
endinterface

>>> hw/rtl/tbaf_out_if.sv
// ============================================================================
// tbaf_out_if
// Output channel: one filtered halfword and its end-of-stream mark per transfer.
// ============================================================================
interface tbaf_out_if
  import tbaf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] out_half;
  logic             out_last;

  modport source (output valid, output out_half, output out_last, input ready);
  modport sink   (input valid, input out_half, input out_last, output ready);
endinterface

>>> hw/rtl/thumb_branch_address_filter.sv
// ============================================================================
// thumb_branch_address_filter
// Pairs Thumb code halfwords, rebases BL targets by the halfword index and
// optionally swaps MOVT nibbles; results leave through a four-entry queue.
// ============================================================================
//
//   channel   dir   payload                     handshake
//   in_i      in    code_half[15:0], is_last    valid/ready
//   out_o     out   out_half[15:0],  out_last   valid/ready
//   cfg       in    cfg_wdata_i[1:0]            cfg_we_i, no stall
//
// One halfword is taken per cycle while in_i.ready is high. Each transfer
// is filtered in the cycle it arrives and writes zero, one or two results
// into the output queue; the queue drains one result per cycle while
// out_o.ready is high, which matches the one-per-halfword average. in_i.ready
// drops only while the queue has fewer than two free entries. Reset clears the
// pairing state and the queue, and sets the mode to subtract with MOVT swap.
module thumb_branch_address_filter
  import tbaf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ModeW-1:0] cfg_wdata_i,
  tbaf_in_if.sink          in_i,
  tbaf_out_if.source       out_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  logic [ModeW-1:0] mode_q;
  logic [HalfW-1:0] held_half_q, held_half_d;
  logic             held_valid_q, held_valid_d;
  logic [IdxW-1:0]  held_idx_q, held_idx_d;
  logic [IdxW-1:0]  count_q, count_d;

  res_t             queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] fill_q, fill_d;

  logic             in_xfer, out_xfer;
  logic [HalfW-1:0] h0, h1;
  logic [IdxW-1:0]  ofs, tgt, tgt_new;
  logic             is_bl, is_movt, is_f000;
  res_t             res0, res1;
  logic [1:0]       push_n;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Classify the pair and rebase the branch target
  assign h0      = held_half_q;
  assign h1      = in_i.code_half;
  assign ofs     = held_idx_q + PcOffset;
  assign tgt     = {h0[FieldW-1:0], h1[FieldW-1:0]};
  assign tgt_new = (mode_q == MODE_ADD) ? tgt + ofs : tgt - ofs;
  assign is_bl   = ((h0 & TopMask) == BlFirst) && ((h1 & TopMask) == BlSecond);
  assign is_movt = (mode_q == MODE_SUB_MOVT) && ((h0 & MovtMask) == MovtMatch)
                   && !h1[HalfW-1];
  assign is_f000 = (h1 & TopMask) == BlFirst;

  // Form the results and the next pairing state
  always_comb begin
    held_half_d  = held_half_q;
    held_valid_d = held_valid_q;
    held_idx_d   = held_idx_q;
    count_d      = count_q;
    res0         = '{half: h0, last: 1'b0};
    res1         = '{half: h1, last: 1'b0};
    push_n       = 2'd0;
    if (in_xfer) begin
      count_d = count_q + 1'b1;
      if (!held_valid_q) begin
        held_half_d  = h1;
        held_idx_d   = count_q;
        held_valid_d = 1'b1;
      end else if (is_bl) begin
        res0.half    = BlFirst  | {{(HalfW-FieldW){1'b0}}, tgt_new[IdxW-1:FieldW]};
        res1.half    = BlSecond | {{(HalfW-FieldW){1'b0}}, tgt_new[FieldW-1:0]};
        push_n       = 2'd2;
        held_valid_d = 1'b0;
      end else if (is_movt) begin
        res0.half    = {h0[15:4], h1[11:8]};
        res1.half    = {h1[15:12], h0[3:0], h1[7:0]};
        push_n       = 2'd2;
        held_valid_d = 1'b0;
      end else if (is_f000) begin
        push_n       = 2'd1;
        held_half_d  = h1;
        held_idx_d   = count_q;
      end else begin
        push_n       = 2'd2;
        held_valid_d = 1'b0;
      end
      // Flush a pending halfword and mark the end of the buffer
      if (in_i.is_last) begin
        if (held_valid_d) begin
          if (push_n == 2'd0) begin
            res0.half = held_half_d;
          end else begin
            res1.half = held_half_d;
          end
          push_n = push_n + 2'd1;
        end
        if (push_n == 2'd1) begin
          res0.last = 1'b1;
        end else if (push_n == 2'd2) begin
          res1.last = 1'b1;
        end
        count_d      = '0;
        held_valid_d = 1'b0;
        held_idx_d   = '0;
        held_half_d  = '0;
      end
    end
  end

  // Advance the pairing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_half_q  <= '0;
      held_idx_q   <= '0;
      count_q      <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_half_q  <= held_half_d;
      held_idx_q   <= held_idx_d;
      count_q      <= count_d;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= res1;
    end
  end

  assign fill_d = fill_q + QCntW'(push_n) - QCntW'(out_xfer);

  // Advance queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_d;
    end
  end

  // Accept input while at least two queue entries are free
  assign in_i.ready     = fill_q <= QCntW'(QDepth - 2);
  assign out_o.valid    = fill_q != '0;
  assign out_o.out_half = queue_q[rd_ptr_q].half;
  assign out_o.out_last = queue_q[rd_ptr_q].last;

endmodule
